/* hdl/sapr_pkg.sv */
package sapr_pkg;

  localparam logic [15:0] TURN = 16'd46080;
  localparam logic signed [16:0] TURN_S = 17'sd46080;
  localparam logic signed [16:0] HALF_TURN_S = 17'sd23040;
  localparam logic [63:0] RATE_DIV = 64'd98304000;
  localparam logic [63:0] ONE_SEC_US = 64'd1000000;
  localparam logic [14:0] IV_MAX = 15'd32767;
  localparam logic [14:0] IV_RESET = 15'd2000;

  // rate divisor is 375 * 2^18; 1/375 is taken as 91625969 / 2^35, exact below 2^26
  localparam logic [63:0] RATE_ODD = 64'd375;
  localparam int RATE_SHIFT = 18;
  localparam int RCP_SHIFT = 35;
  localparam logic signed [16:0] RCP_LO = 17'sd6641;
  localparam logic signed [16:0] RCP_HI = 17'sd1398;

  localparam int DIV_W = 64;
  localparam int DEN_W = 27;
  localparam int CNT_W = 7;
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 17;

  // derivative dividend stays below 2^26, interval dividend below 2^20
  localparam logic [CNT_W-1:0] DERIV_BITS = 7'd27;
  localparam logic [CNT_W-1:0] IV_BITS = 7'd20;

  localparam logic [1:0] STATUS_HELD = 2'd0;
  localparam logic [1:0] STATUS_DEAD = 2'd1;
  localparam logic [1:0] STATUS_DRIVE = 2'd2;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_GAIN_P = 3'd2;
  localparam logic [2:0] REG_GAIN_I = 3'd3;
  localparam logic [2:0] REG_GAIN_D = 3'd4;
  localparam logic [2:0] REG_DEADBAND = 3'd5;
  localparam logic [2:0] REG_MSTEP = 3'd6;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [15:0] turn_reduce(input logic [15:0] x);
    return (x >= TURN) ? x - TURN : x;
  endfunction

endpackage

/* hdl/sapr_in_if.sv */
interface sapr_in_if;
  logic valid;
  logic ready;
  logic [15:0] encoder_angle;
  logic [15:0] elapsed_ms;
  logic [31:0] time_us;

  modport source (output valid, encoder_angle, elapsed_ms, time_us, input ready);
  modport sink (input valid, encoder_angle, elapsed_ms, time_us, output ready);
endinterface

/* hdl/sapr_out_if.sv */
interface sapr_out_if;
  logic valid;
  logic ready;
  logic [15:0] current_angle;
  logic direction;
  logic step_level;
  logic [14:0] step_interval_us;
  logic [1:0] microstep_pins;
  logic [1:0] status;

  modport source (output valid, current_angle, direction, step_level, step_interval_us,
                  microstep_pins, status, input ready);
  modport sink (input valid, current_angle, direction, step_level, step_interval_us,
                microstep_pins, status, output ready);
endinterface

/* hdl/sapr_mul.sv */
module sapr_mul
  import sapr_pkg::*;
(
  input  logic clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [63:0] prod_r
);

  logic signed [MUL_A_W+MUL_B_W-1:0] prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt[63:0];
  end

endmodule

/* hdl/sapr_div.sv */
module sapr_div
  import sapr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic busy_r;
  logic done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, q_r[DIV_W-1]};
    diff = trial - {1'b0, d_r};
    ge = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= req.nbits;
        q_r <= req.dividend;
        rem_r <= '0;
        d_r <= req.divisor;
      end else if (busy_r) begin
        q_r <= {q_r[DIV_W-2:0], ge};
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

/* hdl/stepper_angle_pid_step_rate.sv */
// Position loop for a step/direction stepper driver.
// in_ch carries one control tick (encoder angle, elapsed ms, us timestamp);
// out_ch returns one result per tick: wrapped angle, direction, step level,
// step interval, microstep pin levels and a status code.
// The user must write registers over cfg_we/cfg_index/cfg_wdata only while idle;
// the block itself does not enforce this. A held tick (zero elapsed ms)
// goes straight to the output stage, a tick inside the deadband stops after
// the deadband check, and a driving tick waits on the serial divider, which
// produces one quotient bit a cycle for the derivative (27 bits) and the
// interval (20 bits); the PID products and the reciprocal multiply for the
// step rate go through one shared registered multiplier.
// in_ch.ready is high only while the sequencer is idle. A finished result
// sits in the output register; the next tick may be taken meanwhile, and its
// result waits until out_ch.ready frees the register.
// Synchronous reset clears the registers to zero, the interval to 2000 us,
// the loop state and any pending result.
module stepper_angle_pid_step_rate
  import sapr_pkg::*;
#(
  parameter int FULL_STEPS_PER_REV = 200,
  parameter int MIN_STEP_RATE = 50,
  parameter int MAX_STEP_RATE = 3000
) (
  input  logic clk,
  input  logic rst_n,
  sapr_in_if.sink in_ch,
  sapr_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [63:0] AV_CAP = 64'(MAX_STEP_RATE) * RATE_DIV;
  localparam logic [63:0] RATE_LO = 64'(MIN_STEP_RATE);
  localparam logic [63:0] RATE_HI = 64'(MAX_STEP_RATE);
  localparam logic [63:0] Y_CAP = 64'(MAX_STEP_RATE + 1) * RATE_ODD;

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_ANG  = 23'h000002,
    S_ERR  = 23'h000004,
    S_DB   = 23'h000008,
    S_M1   = 23'h000010,
    S_M2   = 23'h000020,
    S_M3   = 23'h000040,
    S_M4   = 23'h000080,
    S_M5   = 23'h000100,
    S_DWT  = 23'h000200,
    S_M6   = 23'h000400,
    S_M7   = 23'h000800,
    S_M8   = 23'h001000,
    S_AV   = 23'h002000,
    S_MR   = 23'h004000,
    S_RY   = 23'h008000,
    S_RLO  = 23'h010000,
    S_RHI  = 23'h020000,
    S_RSUM = 23'h040000,
    S_IDV  = 23'h080000,
    S_IWT  = 23'h100000,
    S_TOG  = 23'h200000,
    S_EMIT = 23'h400000
  } state_t;

  state_t state_r;

  logic [15:0] tgt_cfg_r, off_cfg_r;
  logic signed [15:0] gp_r, gi_r, gd_r;
  logic [14:0] db_r;
  logic [1:0] mode_r;

  logic [15:0] enc_r, ms_r;
  logic [31:0] time_r;

  logic signed [31:0] integ_r;
  logic signed [16:0] prev_r;
  logic [15:0] held_r;
  logic [14:0] interval_r;
  logic [31:0] last_r;
  logic step_r, dir_r;

  logic signed [16:0] err_r;
  logic signed [63:0] acc_r;
  logic deriv_neg_r;
  logic signed [27:0] deriv_r;
  logic [MUL_A_W-1:0] av_r;
  logic [25:0] y_r;
  logic [16:0] rate_r;
  logic [1:0] status_r;

  logic out_valid_r;
  logic [15:0] out_angle_r;
  logic out_dir_r, out_step_r;
  logic [14:0] out_iv_r;
  logic [1:0] out_pins_r, out_status_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [63:0] prod_r;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [16:0] ang_diff, err_raw, mag;
  logic [15:0] held_nxt;
  logic signed [16:0] err_nxt;
  logic signed [17:0] dchg;
  logic signed [34:0] isum;
  logic signed [31:0] integ_nxt;
  logic [63:0] abs_v, av_nxt;
  logic [63:0] y_shr, y_nxt, rsum, rquo;
  logic [63:0] rq;
  logic [16:0] rate_nxt;
  logic [14:0] iv_nxt;
  logic [31:0] since;
  logic emit_go;

  sapr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));
  sapr_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    ang_diff = $signed({1'b0, turn_reduce(enc_r)}) - $signed({1'b0, turn_reduce(off_cfg_r)});
    held_nxt = (ang_diff < 0) ? 16'(ang_diff + TURN_S) : ang_diff[15:0];

    err_raw = $signed({1'b0, turn_reduce(tgt_cfg_r)}) - $signed({1'b0, held_r});
    if (err_raw > HALF_TURN_S) begin
      err_nxt = err_raw - TURN_S;
    end else if (err_raw < -HALF_TURN_S) begin
      err_nxt = err_raw + TURN_S;
    end else begin
      err_nxt = err_raw;
    end
    mag = (err_r < 0) ? -err_r : err_r;
    dchg = {err_r[16], err_r} - {prev_r[16], prev_r};

    isum = {{3{integ_r[31]}}, integ_r} + prod_r[34:0];
    if (isum[34:31] != {4{isum[34]}}) begin
      integ_nxt = isum[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_nxt = isum[31:0];
    end

    abs_v = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    av_nxt = (abs_v > AV_CAP) ? AV_CAP : abs_v;

    // capping keeps the quotient at max rate + 1, which still clamps to max
    y_shr = 64'(prod_r) >> RATE_SHIFT;
    y_nxt = (y_shr > Y_CAP) ? Y_CAP : y_shr;
    rsum = 64'(acc_r) + (64'(prod_r) << 16);
    rquo = rsum >> RCP_SHIFT;
    if (rquo < RATE_LO) begin
      rate_nxt = 17'(RATE_LO);
    end else if (rquo > RATE_HI) begin
      rate_nxt = 17'(RATE_HI);
    end else begin
      rate_nxt = rquo[16:0];
    end

    rq = div_rsp.quot;
    iv_nxt = (rq > 64'(IV_MAX)) ? IV_MAX : rq[14:0];
    since = time_r - last_r;
  end

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // shared multiplier operands, product is seen one state later
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DB: begin
        mul_a = {{(MUL_A_W-17){err_r[16]}}, err_r};
        mul_b = {1'b0, ms_r};
      end
      S_M1: begin
        mul_a = {{(MUL_A_W-18){dchg[17]}}, dchg};
        mul_b = 17'sd1000;
      end
      S_M2: begin
        mul_a = {{(MUL_A_W-17){err_r[16]}}, err_r};
        mul_b = {gp_r[15], gp_r};
      end
      S_M3, S_M7: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = 17'sd1000;
      end
      S_M4: begin
        mul_a = {{(MUL_A_W-32){integ_r[31]}}, integ_r};
        mul_b = {gi_r[15], gi_r};
      end
      S_M6: begin
        mul_a = {{(MUL_A_W-28){deriv_r[27]}}, deriv_r};
        mul_b = {gd_r[15], gd_r};
      end
      S_MR: begin
        mul_a = av_r;
        mul_b = 17'(FULL_STEPS_PER_REV) << mode_r;
      end
      S_RLO: begin
        mul_a = {{(MUL_A_W-26){1'b0}}, y_r};
        mul_b = RCP_LO;
      end
      S_RHI: begin
        mul_a = {{(MUL_A_W-26){1'b0}}, y_r};
        mul_b = RCP_HI;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      S_M2: begin
        div_req.start = 1'b1;
        div_req.dividend = (prod_r[63] ? 64'(-prod_r) : 64'(prod_r)) << (DIV_W - 27);
        div_req.divisor = {11'd0, ms_r};
        div_req.nbits = DERIV_BITS;
      end
      S_IDV: begin
        div_req.start = 1'b1;
        div_req.dividend = ONE_SEC_US << (DIV_W - 20);
        div_req.divisor = {10'd0, rate_r};
        div_req.nbits = IV_BITS;
      end
      default: div_req = '0;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_cfg_r <= '0;
      off_cfg_r <= '0;
      gp_r <= '0;
      gi_r <= '0;
      gd_r <= '0;
      db_r <= '0;
      mode_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:   tgt_cfg_r <= cfg_wdata;
        REG_OFFSET:   off_cfg_r <= cfg_wdata;
        REG_GAIN_P:   gp_r <= cfg_wdata;
        REG_GAIN_I:   gi_r <= cfg_wdata;
        REG_GAIN_D:   gd_r <= cfg_wdata;
        REG_DEADBAND: db_r <= cfg_wdata[14:0];
        REG_MSTEP:    mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      integ_r <= '0;
      prev_r <= '0;
      held_r <= '0;
      interval_r <= IV_RESET;
      last_r <= '0;
      step_r <= 1'b0;
      dir_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            enc_r <= in_ch.encoder_angle;
            ms_r <= in_ch.elapsed_ms;
            time_r <= in_ch.time_us;
            if (in_ch.elapsed_ms == 16'd0) begin
              status_r <= STATUS_HELD;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_ANG;
            end
          end
        end
        S_ANG: begin
          held_r <= held_nxt;
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r <= err_nxt;
          state_r <= S_DB;
        end
        S_DB: begin
          if (mag < {2'b0, db_r}) begin
            integ_r <= '0;
            prev_r <= err_r;
            status_r <= STATUS_DEAD;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_M1;
          end
        end
        S_M1: begin
          integ_r <= integ_nxt;
          state_r <= S_M2;
        end
        S_M2: begin
          deriv_neg_r <= prod_r[63];
          prev_r <= err_r;
          state_r <= S_M3;
        end
        S_M3: state_r <= S_M4;
        S_M4: begin
          acc_r <= prod_r;
          state_r <= S_M5;
        end
        S_M5: begin
          acc_r <= acc_r + prod_r;
          state_r <= S_DWT;
        end
        S_DWT: begin
          if (div_rsp.done) begin
            deriv_r <= deriv_neg_r ? -$signed({1'b0, div_rsp.quot[26:0]})
                                   : $signed({1'b0, div_rsp.quot[26:0]});
            state_r <= S_M6;
          end
        end
        S_M6: state_r <= S_M7;
        S_M7: state_r <= S_M8;
        S_M8: begin
          acc_r <= acc_r + prod_r;
          state_r <= S_AV;
        end
        S_AV: begin
          av_r <= av_nxt[MUL_A_W-1:0];
          dir_r <= acc_r[63];
          state_r <= S_MR;
        end
        S_MR: state_r <= S_RY;
        S_RY: begin
          y_r <= y_nxt[25:0];
          state_r <= S_RLO;
        end
        S_RLO: state_r <= S_RHI;
        S_RHI: begin
          acc_r <= prod_r;
          state_r <= S_RSUM;
        end
        S_RSUM: begin
          rate_r <= rate_nxt;
          state_r <= S_IDV;
        end
        S_IDV: state_r <= S_IWT;
        S_IWT: begin
          if (div_rsp.done) begin
            interval_r <= iv_nxt;
            state_r <= S_TOG;
          end
        end
        S_TOG: begin
          if (since >= {17'd0, interval_r}) begin
            last_r <= time_r;
            step_r <= ~step_r;
          end
          status_r <= STATUS_DRIVE;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_angle_r <= held_r;
            out_dir_r <= dir_r;
            out_step_r <= step_r;
            out_iv_r <= interval_r;
            out_pins_r <= mode_r;
            out_status_r <= status_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.current_angle = out_angle_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.step_level = out_step_r;
  assign out_ch.step_interval_us = out_iv_r;
  assign out_ch.microstep_pins = out_pins_r;
  assign out_ch.status = out_status_r;

endmodule

/* hdl/sapr_chk.sv */
module sapr_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_current_angle,
  input logic [14:0] out_step_interval_us,
  input logic [1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_current_angle) && $stable(out_step_interval_us) && $stable(out_status))
    else $error("result changed while stalled");

  // one tick in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a transaction");

  a_interval_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_step_interval_us != 15'd0)
    else $error("zero step interval");

endmodule

bind stepper_angle_pid_step_rate sapr_chk u_sapr_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_current_angle(out_ch.current_angle),
  .out_step_interval_us(out_ch.step_interval_us),
  .out_status(out_ch.status)
);

/* tb/tb_stepper_angle_pid_step_rate.sv */
module tb_stepper_angle_pid_step_rate;
  import sapr_pkg::*;

  localparam int STEPS_PER_REV = 200;
  localparam int RATE_FLOOR = 50;
  localparam int RATE_CEIL = 3000;
  localparam longint RATE_SCALE = 98304000;
  localparam int ANGLE_TURN = 46080;
  localparam int ANGLE_HALF = 23040;

  typedef struct {
    logic [15:0] angle;
    logic        dir;
    logic        level;
    logic [14:0] interval;
    logic [1:0]  pins;
    logic [1:0]  status;
  } joint_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  sapr_in_if in_ch ();
  sapr_out_if out_ch ();

  stepper_angle_pid_step_rate u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // loop model state
  logic [15:0] m_target, m_offset;
  shortint     m_kp, m_ki, m_kd;
  logic [14:0] m_deadband;
  logic [1:0]  m_mode;
  longint      m_integral;
  int          m_prev_err;
  logic [15:0] m_angle;
  logic [14:0] m_interval;
  logic [31:0] m_last_toggle;
  logic        m_level, m_dir;

  joint_result_t expected_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  logic [31:0] clock_us;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.encoder_angle = '0;
    in_ch.elapsed_ms = '0;
    in_ch.time_us = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 33);
  end

  function automatic joint_result_t snapshot(logic [1:0] st);
    joint_result_t r;
    r.angle = m_angle;
    r.dir = m_dir;
    r.level = m_level;
    r.interval = m_interval;
    r.pins = m_mode;
    r.status = st;
    return r;
  endfunction

  function automatic joint_result_t control_tick(logic [15:0] enc_raw, logic [15:0] ms_raw,
                                                 logic [31:0] now);
    int enc, off, tgt, err, mag;
    longint ms, acc, deriv, vel, av, rate, iv;
    enc = int'(enc_raw) % ANGLE_TURN;
    ms = longint'(ms_raw);
    if (ms == 0) return snapshot(STATUS_HELD);
    off = int'(m_offset) % ANGLE_TURN;
    m_angle = 16'((enc - off + ANGLE_TURN) % ANGLE_TURN);
    tgt = int'(m_target) % ANGLE_TURN;
    err = tgt - int'(m_angle);
    if (err > ANGLE_HALF) err -= ANGLE_TURN;
    if (err < -ANGLE_HALF) err += ANGLE_TURN;
    mag = (err < 0) ? -err : err;
    if (mag < int'(m_deadband)) begin
      m_integral = 0;
      m_prev_err = err;
      return snapshot(STATUS_DEAD);
    end
    acc = m_integral + longint'(err) * ms;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    m_integral = acc;
    deriv = (longint'(err) - longint'(m_prev_err)) * 1000 / ms;
    m_prev_err = err;
    vel = longint'(m_kp) * err * 1000 + longint'(m_ki) * m_integral
          + longint'(m_kd) * deriv * 1000;
    av = (vel < 0) ? -vel : vel;
    if (av > RATE_CEIL * RATE_SCALE) av = RATE_CEIL * RATE_SCALE;
    rate = av * (longint'(STEPS_PER_REV) << m_mode) / RATE_SCALE;
    if (rate < RATE_FLOOR) rate = RATE_FLOOR;
    if (rate > RATE_CEIL) rate = RATE_CEIL;
    iv = 1000000 / rate;
    if (iv > 32767) iv = 32767;
    m_interval = 15'(iv);
    m_dir = (vel < 0);
    if (32'(now - m_last_toggle) >= 32'(m_interval)) begin
      m_last_toggle = now;
      m_level = ~m_level;
    end
    return snapshot(STATUS_DRIVE);
  endfunction

  always @(posedge clk) begin
    joint_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result angle=%0d status=%0d", $time,
                 out_ch.current_angle, out_ch.status);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.current_angle !== exp_r.angle || out_ch.direction !== exp_r.dir ||
            out_ch.step_level !== exp_r.level || out_ch.step_interval_us !== exp_r.interval ||
            out_ch.microstep_pins !== exp_r.pins || out_ch.status !== exp_r.status) begin
          $display("%0t: expected angle=%0d dir=%0b lvl=%0b iv=%0d pins=%0d st=%0d", $time,
                   exp_r.angle, exp_r.dir, exp_r.level, exp_r.interval, exp_r.pins,
                   exp_r.status);
          $display("%0t:   actual angle=%0d dir=%0b lvl=%0b iv=%0d pins=%0d st=%0d", $time,
                   out_ch.current_angle, out_ch.direction, out_ch.step_level,
                   out_ch.step_interval_us, out_ch.microstep_pins, out_ch.status);
          errors++;
        end
      end
    end
  end

  task automatic send_tick(logic [15:0] enc, logic [15:0] ms, logic [31:0] now);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.encoder_angle = enc;
    in_ch.elapsed_ms = ms;
    in_ch.time_us = now;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(control_tick(enc, ms, now));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TARGET:   m_target = data;
      REG_OFFSET:   m_offset = data;
      REG_GAIN_P:   m_kp = shortint'(data);
      REG_GAIN_I:   m_ki = shortint'(data);
      REG_GAIN_D:   m_kd = shortint'(data);
      REG_DEADBAND: m_deadband = data[14:0];
      REG_MSTEP:    m_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] tgt, logic [15:0] off, logic [15:0] kp,
                              logic [15:0] ki, logic [15:0] kd, logic [15:0] db,
                              logic [1:0] mode);
    wait_idle();
    write_reg(REG_TARGET, tgt);
    write_reg(REG_OFFSET, off);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_MSTEP, {14'd0, mode});
  endtask

  task automatic advance_and_send(logic [15:0] enc, logic [15:0] ms);
    clock_us += $urandom_range(4000);
    send_tick(enc, ms, clock_us);
  endtask

  // zero gains after reset give the slowest rate
  task automatic test_reset_state();
    send_tick(16'd0, 16'd0, 32'd0);
    send_tick(16'd100, 16'd1, 32'd5);
    send_tick(16'd100, 16'd1, 32'd20000);
  endtask

  task automatic test_directed();
    load_setting(16'd0, 16'd0, 16'h7fff, 16'h0000, 16'h0000, 16'd0, 2'd3);
    send_tick(16'd23040, 16'd1, 32'd30000);       // half-turn error
    send_tick(16'd23040, 16'hffff, 32'd30100);
    send_tick(16'hffff, 16'd10, 32'd31000);       // out-of-range encoder
    send_tick(16'd46079, 16'd1, 32'hffff_ff00);
    send_tick(16'd1, 16'd1, 32'h0000_0100);       // timer wrap
    send_tick(16'd5, 16'd0, 32'd0);               // hold
    load_setting(16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 16'd100, 2'd0);
    send_tick(16'd0, 16'd1, 32'd1000);
    send_tick(16'd46079, 16'd1, 32'd2000);
    send_tick(16'd19500, 16'd3, 32'd3000);        // far from target: outside the deadband
    send_tick(16'd19400, 16'd2, 32'd9000);
    send_tick(16'd30000, 16'd1, 32'd40000);
    load_setting(16'd46079, 16'd46079, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 2'd1);
    send_tick(16'd0, 16'd1, 32'd50000);           // every error inside the band
    send_tick(16'd23040, 16'd2, 32'd60000);
    load_setting(16'd1000, 16'd0, 16'h0100, 16'h0001, 16'hff00, 16'd0, 2'd2);
    send_tick(16'd0, 16'd1, 32'd70000);
    send_tick(16'd2000, 16'd1, 32'd70001);
    send_tick(16'd1000, 16'd1, 32'd90000);
    send_tick(16'd999, 16'd1, 32'd90001);
  endtask

  task automatic test_random_phase(int n);
    logic [15:0] enc, ms, tgt;
    int r;
    load_setting(16'($urandom_range(46079)), 16'($urandom_range(46079)),
                 16'($urandom), 16'($urandom_range(0, 1) ? $urandom_range(64) : $urandom),
                 16'($urandom), 16'($urandom_range(2000)), 2'($urandom_range(3)));
    tgt = 16'((int'(m_target) + int'(m_offset)) % ANGLE_TURN);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 55) enc = 16'((int'(tgt) + $urandom_range(6000) + ANGLE_TURN - 3000) % ANGLE_TURN);
      else if (r < 90) enc = 16'($urandom_range(46079));
      else enc = 16'($urandom);
      r = $urandom_range(99);
      if (r < 8) ms = 16'd0;
      else if (r < 85) ms = 16'($urandom_range(1, 50));
      else ms = 16'($urandom);
      if ($urandom_range(99) < 3) clock_us = $urandom;
      advance_and_send(enc, ms);
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 34; ph++) begin
      no_idle = (ph >= 12 && ph < 17);
      test_random_phase(50);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    m_target = '0; m_offset = '0; m_kp = 0; m_ki = 0; m_kd = 0;
    m_deadband = '0; m_mode = '0;
    m_integral = 0; m_prev_err = 0; m_angle = '0; m_interval = IV_RESET;
    m_last_toggle = '0; m_level = 1'b0; m_dir = 1'b0;
    clock_us = 32'hffff_0000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("stepper_angle_pid_step_rate: match");
    end else begin
      $display("stepper_angle_pid_step_rate: mismatch");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("stepper_angle_pid_step_rate: mismatch");
    $finish;
  end

endmodule

/* stepper_angle_pid_step_rate.f */
hdl/sapr_pkg.sv
hdl/sapr_in_if.sv
hdl/sapr_out_if.sv
hdl/sapr_mul.sv
hdl/sapr_div.sv
hdl/stepper_angle_pid_step_rate.sv
hdl/sapr_chk.sv
tb/tb_stepper_angle_pid_step_rate.sv
